// File: rtl/core/circle_outline_fill_raster_macros.svh
// Assertion macros used by the circle rasterizer checker.
`ifndef CIRCLE_OUTLINE_FILL_RASTER_MACROS_SVH
`define CIRCLE_OUTLINE_FILL_RASTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define COFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cofr assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define COFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cofr assertion failed");

`endif

// File: rtl/core/cofr_pkg.sv
// Types and constants of the circle rasterizer.
package cofr_pkg;

	localparam int MAX_DIM = 4096;
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int OFS_W   = 11;
	localparam int SQ_W    = 23;
	localparam int SUM_W   = 24;
	localparam int R2_W    = 22;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS     = 3'd2;
	localparam logic [IDX_W-1:0] REG_FILL_MODE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRAW_COLOR = 3'd4;
	localparam logic [IDX_W-1:0] REG_FRAME_W    = 3'd5;
	localparam logic [IDX_W-1:0] REG_FRAME_H    = 3'd6;

	typedef struct packed {
		logic [3:0]         mask;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic               done;
	} step_res_t;

endpackage

// File: rtl/core/circle_outline_fill_raster.sv
// Circle rasterizer top level: registers, offset walk and mirrored pixel write emitter.
// The first result of a step is presented from the result register, after the step has passed the input register.
// One step per cycle when each gives one result and result_ready is high; a step with several mirrored writes
// holds the result register until its last write is taken, at most four writes per step.
// The result port emits one transfer per cycle while result_ready is high, which sets the rate of drawn points.
// Reset clears all registers to their defaults; the walk starts idle until a restart.
module circle_outline_fill_raster (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cofr_pkg::ADDR_W-1:0]       paddr,
	input  logic [cofr_pkg::DATA_W-1:0]       pwdata,
	output logic [cofr_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              step_valid,
	output logic                              step_ready,
	input  logic                              restart,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [cofr_pkg::COORD_W-1:0]      pixel_x,
	output logic [cofr_pkg::COORD_W-1:0]      pixel_y,
	output logic [cofr_pkg::COLOR_W-1:0]      pixel_color,
	output logic                              write_valid,
	output logic                              last_of_step,
	output logic                              done_res
);

	logic [cofr_pkg::COORD_W-1:0] center_x_q, center_y_q;
	logic [cofr_pkg::OFS_W-1:0]   radius_q;
	logic [cofr_pkg::R2_W-1:0]    r2_q, r2_wr;
	logic                         fill_mode_q;
	logic [cofr_pkg::COLOR_W-1:0] draw_color_q;
	logic [cofr_pkg::DIM_W-1:0]   frame_w_q, frame_h_q;
	logic                         cfg_wr;
	logic [cofr_pkg::IDX_W-1:0]   cfg_idx;

	logic                         valid_s1, restart_s1;
	logic                         valid_s2;
	cofr_pkg::step_res_t          res_s2, res_d;
	logic                         adv, load_s2, last_item;
	logic [3:0]                   mask_rest;

	logic [cofr_pkg::OFS_W-1:0]   col_q, row_q;
	logic [cofr_pkg::SQ_W-1:0]    cs_q, csp_q, csn_q, rs_q, rsp_q, rsn_q;
	logic                         fin_q;

	logic [cofr_pkg::OFS_W-1:0]   col_e, row_e, col_n, row_n;
	logic [cofr_pkg::SQ_W-1:0]    cs_e, csp_e, csn_e, rs_e, rsp_e, rsn_e;
	logic [cofr_pkg::SQ_W-1:0]    cs_n, csp_n, csn_n, rs_n, rsp_n, rsn_n;
	logic                         fin_e, fin_n, live, draw, row_end, col_end, walk_end;
	logic [cofr_pkg::SUM_W-1:0]   r2x, sum_c, sum_cp, sum_cn, sum_rp, sum_rn;
	logic [cofr_pkg::DIM_W-1:0]   wl, hl, x0, y0;
	logic [cofr_pkg::COORD_W-1:0] x1, y1;
	logic                         xok0, xok1, yok0, yok1;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[cofr_pkg::ADDR_W-1:2];
	assign r2_wr   = cofr_pkg::R2_W'(pwdata[cofr_pkg::OFS_W-1:0])
		* cofr_pkg::R2_W'(pwdata[cofr_pkg::OFS_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= '0;
			center_y_q   <= '0;
			radius_q     <= cofr_pkg::OFS_W'(1);
			r2_q         <= cofr_pkg::R2_W'(1);
			fill_mode_q  <= 1'b0;
			draw_color_q <= '0;
			frame_w_q    <= cofr_pkg::DIM_W'(cofr_pkg::MAX_DIM);
			frame_h_q    <= cofr_pkg::DIM_W'(cofr_pkg::MAX_DIM);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				cofr_pkg::REG_CENTER_X: center_x_q <= pwdata[cofr_pkg::COORD_W-1:0];
				cofr_pkg::REG_CENTER_Y: center_y_q <= pwdata[cofr_pkg::COORD_W-1:0];
				cofr_pkg::REG_RADIUS: begin
					radius_q <= pwdata[cofr_pkg::OFS_W-1:0];
					r2_q     <= r2_wr;
				end
				cofr_pkg::REG_FILL_MODE:  fill_mode_q  <= pwdata[0];
				cofr_pkg::REG_DRAW_COLOR: draw_color_q <= pwdata[cofr_pkg::COLOR_W-1:0];
				cofr_pkg::REG_FRAME_W:    frame_w_q    <= pwdata[cofr_pkg::DIM_W-1:0];
				cofr_pkg::REG_FRAME_H:    frame_h_q    <= pwdata[cofr_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			cofr_pkg::REG_CENTER_X:   prdata = cofr_pkg::DATA_W'(center_x_q);
			cofr_pkg::REG_CENTER_Y:   prdata = cofr_pkg::DATA_W'(center_y_q);
			cofr_pkg::REG_RADIUS:     prdata = cofr_pkg::DATA_W'(radius_q);
			cofr_pkg::REG_FILL_MODE:  prdata = cofr_pkg::DATA_W'(fill_mode_q);
			cofr_pkg::REG_DRAW_COLOR: prdata = cofr_pkg::DATA_W'(draw_color_q);
			cofr_pkg::REG_FRAME_W:    prdata = cofr_pkg::DATA_W'(frame_w_q);
			cofr_pkg::REG_FRAME_H:    prdata = cofr_pkg::DATA_W'(frame_h_q);
			default:                  prdata = '0;
		endcase
	end

	// Handshake between the input register and the result register.
	assign mask_rest  = res_s2.mask & (res_s2.mask - 4'd1);
	assign last_item  = (mask_rest == 4'd0);
	assign load_s2    = !valid_s2 || (result_ready && last_item);
	assign adv        = valid_s1 && load_s2;
	assign step_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			restart_s1 <= 1'b0;
		end else if (step_ready) begin
			valid_s1   <= step_valid;
			restart_s1 <= restart;
		end
	end

	// A restart evaluates offset zero in the same step.
	always_comb begin
		if (restart_s1) begin
			col_e = '0;
			row_e = '0;
			cs_e  = '0;
			csp_e = '0;
			csn_e = cofr_pkg::SQ_W'(1);
			rs_e  = '0;
			rsp_e = '0;
			rsn_e = cofr_pkg::SQ_W'(1);
			fin_e = 1'b0;
		end else begin
			col_e = col_q;
			row_e = row_q;
			cs_e  = cs_q;
			csp_e = csp_q;
			csn_e = csn_q;
			rs_e  = rs_q;
			rsp_e = rsp_q;
			rsn_e = rsn_q;
			fin_e = fin_q;
		end
	end

	assign live   = !fin_e;
	assign r2x    = cofr_pkg::SUM_W'(r2_q);
	assign sum_c  = cofr_pkg::SUM_W'(cs_e) + cofr_pkg::SUM_W'(rs_e);
	assign sum_cp = cofr_pkg::SUM_W'(csp_e) + cofr_pkg::SUM_W'(rs_e);
	assign sum_cn = cofr_pkg::SUM_W'(csn_e) + cofr_pkg::SUM_W'(rs_e);
	assign sum_rp = cofr_pkg::SUM_W'(cs_e) + cofr_pkg::SUM_W'(rsp_e);
	assign sum_rn = cofr_pkg::SUM_W'(cs_e) + cofr_pkg::SUM_W'(rsn_e);

	assign draw = live && (sum_c < r2x) &&
		(fill_mode_q || (col_e == '0) || (row_e == '0) ||
		 (sum_cp > r2x) || (sum_cn > r2x) || (sum_rp > r2x) || (sum_rn > r2x));

	assign row_end  = ({1'b0, row_e} + 12'd1) >= {1'b0, radius_q};
	assign walk_end = ({1'b0, col_e} + 12'd1) >= {1'b0, radius_q};
	assign col_end  = live && (!draw || row_end);

	always_comb begin
		col_n = col_e;
		row_n = row_e;
		cs_n  = cs_e;
		csp_n = csp_e;
		csn_n = csn_e;
		rs_n  = rs_e;
		rsp_n = rsp_e;
		rsn_n = rsn_e;
		fin_n = fin_e;
		if (draw) begin
			rsp_n = rs_e;
			rs_n  = rsn_e;
			rsn_n = rsn_e + cofr_pkg::SQ_W'({row_e, 1'b0}) + cofr_pkg::SQ_W'(3);
			row_n = row_e + cofr_pkg::OFS_W'(1);
		end
		if (col_end) begin
			csp_n = cs_e;
			cs_n  = csn_e;
			csn_n = csn_e + cofr_pkg::SQ_W'({col_e, 1'b0}) + cofr_pkg::SQ_W'(3);
			col_n = col_e + cofr_pkg::OFS_W'(1);
			row_n = '0;
			rs_n  = '0;
			rsp_n = '0;
			rsn_n = cofr_pkg::SQ_W'(1);
			if (walk_end) begin
				fin_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cs_q  <= '0;
			csp_q <= '0;
			csn_q <= cofr_pkg::SQ_W'(1);
			rs_q  <= '0;
			rsp_q <= '0;
			rsn_q <= cofr_pkg::SQ_W'(1);
			fin_q <= 1'b1;
		end else if (adv) begin
			col_q <= col_n;
			row_q <= row_n;
			cs_q  <= cs_n;
			csp_q <= csp_n;
			csn_q <= csn_n;
			rs_q  <= rs_n;
			rsp_q <= rsp_n;
			rsn_q <= rsn_n;
			fin_q <= fin_n;
		end
	end

	// Mirrored coordinates, clipped to the frame and to the largest frame size.
	assign wl = (frame_w_q < cofr_pkg::DIM_W'(cofr_pkg::MAX_DIM)) ? frame_w_q
		: cofr_pkg::DIM_W'(cofr_pkg::MAX_DIM);
	assign hl = (frame_h_q < cofr_pkg::DIM_W'(cofr_pkg::MAX_DIM)) ? frame_h_q
		: cofr_pkg::DIM_W'(cofr_pkg::MAX_DIM);
	assign x0   = cofr_pkg::DIM_W'(center_x_q) + cofr_pkg::DIM_W'(col_e);
	assign y0   = cofr_pkg::DIM_W'(center_y_q) + cofr_pkg::DIM_W'(row_e);
	assign x1   = center_x_q - cofr_pkg::COORD_W'(col_e);
	assign y1   = center_y_q - cofr_pkg::COORD_W'(row_e);
	assign xok0 = x0 < wl;
	assign yok0 = y0 < hl;
	assign xok1 = (cofr_pkg::COORD_W'(col_e) <= center_x_q) && ({1'b0, x1} < wl);
	assign yok1 = (cofr_pkg::COORD_W'(row_e) <= center_y_q) && ({1'b0, y1} < hl);

	always_comb begin
		res_d.mask = draw ? {xok1 && yok1, xok0 && yok1, xok1 && yok0, xok0 && yok0}
			: 4'd0;
		res_d.x0   = x0[cofr_pkg::COORD_W-1:0];
		res_d.x1   = x1;
		res_d.y0   = y0[cofr_pkg::COORD_W-1:0];
		res_d.y1   = y1;
		res_d.done = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (adv) begin
			res_s2 <= res_d;
		end else if (valid_s2 && result_ready) begin
			res_s2.mask <= mask_rest;
		end
	end

	// The lowest pending write goes out first; an empty mask is one idle transfer.
	always_comb begin
		write_valid  = res_s2.mask != 4'd0;
		pixel_x      = '0;
		pixel_y      = '0;
		pixel_color  = write_valid ? draw_color_q : '0;
		if (res_s2.mask[0]) begin
			pixel_x = res_s2.x0;
			pixel_y = res_s2.y0;
		end else if (res_s2.mask[1]) begin
			pixel_x = res_s2.x1;
			pixel_y = res_s2.y0;
		end else if (res_s2.mask[2]) begin
			pixel_x = res_s2.x0;
			pixel_y = res_s2.y1;
		end else if (res_s2.mask[3]) begin
			pixel_x = res_s2.x1;
			pixel_y = res_s2.y1;
		end
	end

	assign result_valid = valid_s2;
	assign last_of_step = last_item;
	assign done_res     = res_s2.done;

endmodule

// File: rtl/core/cofr_checker.sv
// Port-level checker for the circle rasterizer result channel, bound to the top level.
`include "circle_outline_fill_raster_macros.svh"

module cofr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [cofr_pkg::COORD_W-1:0] pixel_x,
	input logic [cofr_pkg::COORD_W-1:0] pixel_y,
	input logic [cofr_pkg::COLOR_W-1:0] pixel_color,
	input logic                         write_valid,
	input logic                         last_of_step,
	input logic                         done_res
);

	// A stalled transfer keeps its coordinates, write flag and last flag.
	`COFR_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(write_valid) && $stable(last_of_step))

	// A result that is not a pixel write carries zero coordinates and color.
	`COFR_ASSERT_NOW(a_idle_zero, result_valid && !write_valid, pixel_x == '0 && pixel_y == '0 && pixel_color == '0)

	// A result without a write is always the only result of its step.
	`COFR_ASSERT_NOW(a_idle_last, result_valid && !write_valid, last_of_step)

	// Writes of one step follow back to back with the same completion flag.
	`COFR_ASSERT_NEXT(a_step_run, result_valid && result_ready && !last_of_step, result_valid && write_valid && done_res == $past(done_res))

endmodule

bind circle_outline_fill_raster cofr_checker u_cofr_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench of the circle rasterizer with a directed table and random circle walks.
`timescale 1ns / 100ps

module tb;
	import cofr_pkg::*;

	localparam int ITEM_TARGET = 470;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RUN_CAP     = 120;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam bit [1:0] ROW_WRITE = 2'd0;
	localparam bit [1:0] ROW_STEP  = 2'd1;
	localparam bit [1:0] ROW_KNOWN = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               wv;
		logic               last;
		logic               done;
	} pixel_t;

	typedef struct packed {
		bit [1:0]           kind;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  value;
		bit                 rst;
		bit [2:0]           n;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               wv;
		logic               done;
	} row_t;

	localparam row_t PLAN [48] = '{
		'{kind: ROW_KNOWN, rst: 1'b0, n: 3'd1, done: 1'b1, default: '0},
		'{kind: ROW_KNOWN, rst: 1'b1, n: 3'd4, wv: 1'b1, done: 1'b1, default: '0},
		'{kind: ROW_KNOWN, rst: 1'b0, n: 3'd1, done: 1'b1, default: '0},
		'{kind: ROW_WRITE, idx: REG_CENTER_X, value: 32'hFFFF_FFFF, default: '0},
		'{kind: ROW_WRITE, idx: REG_CENTER_Y, value: 32'h0000_0FFF, default: '0},
		'{kind: ROW_WRITE, idx: REG_DRAW_COLOR, value: 32'hFFFF_FFFF, default: '0},
		'{kind: ROW_WRITE, idx: REG_RADIUS, value: 32'd3, default: '0},
		'{kind: ROW_WRITE, idx: REG_FILL_MODE, value: 32'd1, default: '0},
		'{kind: ROW_KNOWN, rst: 1'b1, n: 3'd4, x: 12'd4095, y: 12'd4095,
			color: 32'hFFFF_FFFF, wv: 1'b1, done: 1'b0, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_WRITE, idx: REG_CENTER_X, value: 32'd0, default: '0},
		'{kind: ROW_WRITE, idx: REG_CENTER_Y, value: 32'd0, default: '0},
		'{kind: ROW_WRITE, idx: REG_FILL_MODE, value: 32'd0, default: '0},
		'{kind: ROW_WRITE, idx: REG_RADIUS, value: 32'd2047, default: '0},
		'{kind: ROW_WRITE, idx: REG_FRAME_W, value: 32'hFFFF_FFFF, default: '0},
		'{kind: ROW_WRITE, idx: REG_FRAME_H, value: 32'h0000_1FFF, default: '0},
		'{kind: ROW_KNOWN, rst: 1'b1, n: 3'd4, x: 12'd0, y: 12'd0,
			color: 32'hFFFF_FFFF, wv: 1'b1, done: 1'b0, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_WRITE, idx: REG_RADIUS, value: 32'd1, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_WRITE, idx: REG_FRAME_W, value: 32'd0, default: '0},
		'{kind: ROW_KNOWN, rst: 1'b1, n: 3'd1, done: 1'b1, default: '0},
		'{kind: ROW_WRITE, idx: REG_FRAME_W, value: 32'd4096, default: '0},
		'{kind: ROW_WRITE, idx: REG_RADIUS, value: 32'd0, default: '0},
		'{kind: ROW_KNOWN, rst: 1'b1, n: 3'd1, done: 1'b1, default: '0},
		'{kind: ROW_WRITE, idx: REG_UNUSED, value: 32'd5, default: '0},
		'{kind: ROW_WRITE, idx: REG_RADIUS, value: 32'd6, default: '0},
		'{kind: ROW_WRITE, idx: REG_CENTER_X, value: 32'd3, default: '0},
		'{kind: ROW_WRITE, idx: REG_CENTER_Y, value: 32'd2, default: '0},
		'{kind: ROW_WRITE, idx: REG_FRAME_W, value: 32'd7, default: '0},
		'{kind: ROW_WRITE, idx: REG_FRAME_H, value: 32'd5, default: '0},
		'{kind: ROW_STEP, rst: 1'b1, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0},
		'{kind: ROW_STEP, default: '0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               step_valid = 1'b0;
	logic               step_ready;
	logic               restart = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               write_valid;
	logic               last_of_step;
	logic               done_res;

	logic [COORD_W-1:0] set_cx = '0;
	logic [COORD_W-1:0] set_cy = '0;
	logic [OFS_W-1:0]   set_radius = 11'd1;
	logic               set_fill = 1'b0;
	logic [COLOR_W-1:0] set_color = '0;
	logic [DIM_W-1:0]   set_fw = 13'd4096;
	logic [DIM_W-1:0]   set_fh = 13'd4096;

	logic [OFS_W-1:0]   col_ofs = '0;
	logic [OFS_W-1:0]   row_ofs = '0;
	logic [SQ_W-1:0]    csq = '0;
	logic [SQ_W-1:0]    csq_prev = '0;
	logic [SQ_W-1:0]    csq_next = 23'd1;
	logic [SQ_W-1:0]    rsq = '0;
	logic [SQ_W-1:0]    rsq_prev = '0;
	logic [SQ_W-1:0]    rsq_next = 23'd1;
	bit                 walk_done = 1'b1;

	pixel_t writes_due[$];
	pixel_t point_writes[$];
	int     errors = 0;
	int     points_walked = 0;
	int     items_sent = 0;
	int     cycle_count = 0;
	wire    steady = points_walked >= 200 && points_walked < 300;

	circle_outline_fill_raster u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic void clear_rows();
		row_ofs = '0;
		rsq = '0;
		rsq_prev = '0;
		rsq_next = 23'd1;
	endfunction

	function automatic void next_column();
		int unsigned i;
		i = 32'(col_ofs);
		csq_prev = csq;
		csq = csq_next;
		csq_next = SQ_W'(32'(csq_next) + 2 * i + 3);
		clear_rows();
		col_ofs = OFS_W'(i + 1);
		if (i + 1 >= 32'(set_radius))
			walk_done = 1'b1;
	endfunction

	// Evaluates one offset point and leaves the mirrored, clipped writes in point_writes.
	function automatic void walk_point(bit rst);
		int unsigned i, j, r2, wl, hl;
		int unsigned xs[2], ys[2];
		bit xok[2], yok[2];
		bit draw;
		int a, b;
		point_writes.delete();
		if (rst) begin
			col_ofs = '0;
			csq = '0;
			csq_prev = '0;
			csq_next = 23'd1;
			clear_rows();
			walk_done = 1'b0;
		end
		if (!walk_done) begin
			points_walked++;
			i = 32'(col_ofs);
			j = 32'(row_ofs);
			r2 = 32'(set_radius);
			r2 = r2 * r2;
			draw = (32'(csq) + 32'(rsq) < r2) && (set_fill || i == 0 || j == 0 ||
				32'(csq_prev) + 32'(rsq) > r2 || 32'(csq_next) + 32'(rsq) > r2 ||
				32'(csq) + 32'(rsq_prev) > r2 || 32'(csq) + 32'(rsq_next) > r2);
			if (draw) begin
				wl = (32'(set_fw) < MAX_DIM) ? 32'(set_fw) : MAX_DIM;
				hl = (32'(set_fh) < MAX_DIM) ? 32'(set_fh) : MAX_DIM;
				xs[0] = 32'(set_cx) + i;
				xok[0] = xs[0] < wl;
				xok[1] = i <= 32'(set_cx);
				xs[1] = xok[1] ? 32'(set_cx) - i : 0;
				xok[1] = xok[1] && xs[1] < wl;
				ys[0] = 32'(set_cy) + j;
				yok[0] = ys[0] < hl;
				yok[1] = j <= 32'(set_cy);
				ys[1] = yok[1] ? 32'(set_cy) - j : 0;
				yok[1] = yok[1] && ys[1] < hl;
				for (b = 0; b < 2; b++)
					for (a = 0; a < 2; a++)
						if (xok[a] && yok[b])
							point_writes.push_back('{x: xs[a][COORD_W-1:0],
								y: ys[b][COORD_W-1:0], color: set_color,
								wv: 1'b1, last: 1'b0, done: 1'b0});
				rsq_prev = rsq;
				rsq = rsq_next;
				rsq_next = SQ_W'(32'(rsq_next) + 2 * j + 3);
				row_ofs = OFS_W'(j + 1);
				if (j + 1 >= 32'(set_radius))
					next_column();
			end else begin
				next_column();
			end
		end
		if (point_writes.size() == 0)
			point_writes.push_back('0);
		foreach (point_writes[k])
			point_writes[k].done = walk_done;
		point_writes[point_writes.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [DATA_W-1:0] pick_setting(logic [IDX_W-1:0] idx);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		case (idx)
			REG_CENTER_X, REG_CENTER_Y: begin
				case (roll % 4)
					0: return $urandom;
					1: return $urandom_range(0, 20);
					2: return $urandom_range(4075, 4095);
					default: return $urandom_range(0, 4095);
				endcase
			end
			REG_RADIUS: begin
				case (roll)
					0: return 0;
					1: return 2047;
					2: return $urandom;
					3: return $urandom_range(11, 40);
					default: return $urandom_range(1, 10);
				endcase
			end
			REG_FRAME_W, REG_FRAME_H: begin
				case (roll)
					0: return 0;
					1: return $urandom;
					2, 3, 4, 5: return $urandom_range(1, 40);
					default: return 4096;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CENTER_X:   set_cx = value[COORD_W-1:0];
			REG_CENTER_Y:   set_cy = value[COORD_W-1:0];
			REG_RADIUS:     set_radius = value[OFS_W-1:0];
			REG_FILL_MODE:  set_fill = value[0];
			REG_DRAW_COLOR: set_color = value[COLOR_W-1:0];
			REG_FRAME_W:    set_fw = value[DIM_W-1:0];
			REG_FRAME_H:    set_fh = value[DIM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		step_valid <= 1'b0;
		do @(posedge clk); while (writes_due.size() != 0);
	endtask

	task automatic send_step(input bit rst, input bit known, input row_t row);
		int q;
		while (!steady && $urandom_range(0, 99) < 11) begin
			step_valid <= 1'b0;
			restart <= 1'($urandom);
			@(posedge clk);
		end
		step_valid <= 1'b1;
		restart <= rst;
		do @(posedge clk); while (!step_ready);
		items_sent++;
		walk_point(rst);
		if (known) begin
			for (q = 0; q < int'(row.n); q++)
				writes_due.push_back('{x: row.x, y: row.y, color: row.color, wv: row.wv,
					last: q == int'(row.n) - 1, done: row.done});
		end else begin
			foreach (point_writes[k])
				writes_due.push_back(point_writes[k]);
		end
	endtask

	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n) begin
			result_ready <= steady || ($urandom_range(0, 99) >= 11);
			if (result_valid && result_ready) begin
				got = {pixel_x, pixel_y, pixel_color, write_valid, last_of_step, done_res};
				if (writes_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected transfer: x=%0d y=%0d c=%h v=%b l=%b d=%b",
							got.x, got.y, got.color, got.wv, got.last, got.done);
				end else begin
					want = writes_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %0d %0d %h %b %b %b, got %0d %0d %h %b %b %b",
								want.x, want.y, want.color, want.wv, want.last, want.done,
								got.x, got.y, got.color, got.wv, got.last, got.done);
					end
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned k, run;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[p]) begin
			if (PLAN[p].kind == ROW_WRITE) begin
				drain();
				write_reg(PLAN[p].idx, PLAN[p].value);
			end else begin
				send_step(PLAN[p].rst, PLAN[p].kind == ROW_KNOWN, PLAN[p]);
			end
		end

		// Mostly whole circles from a restart; some phases resume the walk under new settings.
		while (items_sent < ITEM_TARGET) begin
			drain();
			for (k = 0; k <= 32'(REG_FRAME_H); k++)
				if ($urandom_range(0, 1))
					write_reg(k[IDX_W-1:0], pick_setting(k[IDX_W-1:0]));
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					send_step($urandom_range(0, 3) == 0, 1'b0, '0);
			end else begin
				if ($urandom_range(0, 3) != 0)
					send_step(1'b1, 1'b0, '0);
				run = 0;
				while (!walk_done && run < RUN_CAP && items_sent < ITEM_TARGET) begin
					send_step($urandom_range(0, 199) == 0, 1'b0, '0);
					run++;
				end
				repeat ($urandom_range(0, 2))
					send_step(1'b0, 1'b0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && writes_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
